// ===== rtl/sliding_window_median_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Sliding window median unit - assertion macros
// Shared property templates for the port checker.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_MEDIAN_UNIT_MACROS_SVH
`define SLIDING_WINDOW_MEDIAN_UNIT_MACROS_SVH

// same-cycle implication
`define SWM_ASSERT_NOW(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("swm check failed: label");

// next-cycle implication
`define SWM_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("swm check failed: label");

// next-cycle implication that also looks through reset
`define SWM_ASSERT_FROM_RESET(label, clk, lhs, rhs) \
   label: assert property (@(posedge clk) (lhs) |=> (rhs)) \
      else $error("swm check failed: label");

`endif

// ===== rtl/swm_pkg.sv =====
// ----------------------------------------------------------------------------
// Sliding window median - package
// Field widths, the window size reset value and the control bundle broadcast to the cells.
// ----------------------------------------------------------------------------
package swm_pkg;

   localparam int SAMPLE_W = 32;
   localparam int MEDIAN_W = 33;
   localparam int WSIZE_W  = 7;

   localparam logic [WSIZE_W-1:0] WSIZE_RESET = 7'd3;

   typedef struct packed {
      logic                       load;
      logic                       full;
      logic signed [SAMPLE_W-1:0] sample;
   } swm_ctrl_type;

endpackage

// ===== rtl/swm_cell.sv =====
// ----------------------------------------------------------------------------
// Sliding window median - sorted cell
// One slot of the sorted window: holds a sample and its ring slot tag, drops
// the leaving sample and opens a gap for the new one in step with neighbors.
// ----------------------------------------------------------------------------
module swm_cell
   import swm_pkg::*;
#(
   parameter int INDEX = 0,
   parameter int CW    = 7,
   parameter int TW    = 6
) (
   input  logic                       clock,
   input  swm_ctrl_type               ctrl,
   input  logic [CW-1:0]              count,
   input  logic [TW-1:0]              old_tag,
   input  logic [TW-1:0]              new_tag,
   input  logic signed [SAMPLE_W-1:0] nxt_value,
   input  logic [TW-1:0]              nxt_tag,
   input  logic                       nxt_gt,
   input  logic signed [SAMPLE_W-1:0] prv_sh_value,
   input  logic [TW-1:0]              prv_sh_tag,
   input  logic                       prv_sh_gt,
   input  logic                       prv_rem,
   output logic signed [SAMPLE_W-1:0] value,
   output logic [TW-1:0]              tag,
   output logic                       gt,
   output logic                       rem,
   output logic signed [SAMPLE_W-1:0] sh_value,
   output logic [TW-1:0]              sh_tag,
   output logic                       sh_gt
);

   logic signed [SAMPLE_W-1:0] value_ff, value_in;
   logic [TW-1:0]              tag_ff, tag_in;
   logic                       occupied;
   logic                       del;

   always_comb begin
      occupied = count > CW'(INDEX);
      gt       = !occupied || (value_ff > ctrl.sample);
      del      = ctrl.full && occupied && (tag_ff == old_tag);
      rem      = prv_rem || del;
      sh_value = rem ? nxt_value : value_ff;
      sh_tag   = rem ? nxt_tag : tag_ff;
      sh_gt    = rem ? nxt_gt : gt;
      if (!sh_gt) begin
         value_in = sh_value;
         tag_in   = sh_tag;
      end else if (!prv_sh_gt) begin
         value_in = ctrl.sample;
         tag_in   = new_tag;
      end else begin
         value_in = prv_sh_value;
         tag_in   = prv_sh_tag;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         value_ff <= value_in;
         tag_ff   <= tag_in;
      end
   end

   assign value = value_ff;
   assign tag   = tag_ff;

endmodule

// ===== rtl/sliding_window_median_unit.sv =====
// ----------------------------------------------------------------------------
// Sliding window median unit
// Running median over the last window_size samples, kept in a sorted row of
// cells; result is the sum of the two middle cells (median times two).
//
//   channel  direction  ports
//   req      in         req_valid, req_ready, req_sample, req_restart
//   rsp      out        rsp_valid, rsp_ready, rsp_median_doubled
//   csr      in         csr_write_enable, csr_write_data
//
// One item per cycle while req_ready is high; the cell row updates in the accept cycle.
// An item that fills the window sets pend_ff, which loads median_ff and rsp_valid once rsp is free.
// Synchronous reset empties the window and sets window_size to 3.
// A stalled result holds one more item in flight, then req_ready drops.
// ----------------------------------------------------------------------------
module sliding_window_median_unit
   import swm_pkg::*;
#(
   parameter int WINDOW_MAX = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   input  logic                       req_restart,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [MEDIAN_W-1:0] rsp_median_doubled,
   input  logic                       csr_write_enable,
   input  logic [WSIZE_W-1:0]         csr_write_data
);

   localparam int CW   = $clog2(WINDOW_MAX + 1);
   localparam int TW   = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int CMPW = (CW > WSIZE_W) ? CW : WSIZE_W;

   logic [WSIZE_W-1:0]         window_size_ff, window_size_in;
   logic [CW-1:0]              fill_ff, fill_in;
   logic [TW-1:0]              oldest_ff, oldest_in;
   logic                       pend_ff, pend_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [MEDIAN_W-1:0] median_ff, median_in;

   logic [CMPW-1:0]            ws_ext;
   logic [CMPW-1:0]            w_ext;
   logic [CW-1:0]              w;
   logic [CW-1:0]              fill_eff;
   logic [CW-1:0]              oldest_eff;
   logic [CW-1:0]              oldest_inc;
   logic [CW-1:0]              fill_new;
   logic                       full;
   logic                       accept;
   logic                       pend_go;
   logic                       emit;
   logic [CW-1:0]              count;
   logic [TW-1:0]              old_tag;
   logic [TW-1:0]              new_tag;
   logic [TW-1:0]              lo_idx;
   logic [TW-1:0]              hi_idx;
   logic signed [SAMPLE_W-1:0] lo_value;
   logic signed [SAMPLE_W-1:0] hi_value;
   swm_ctrl_type               ctrl;

   logic signed [SAMPLE_W-1:0] cell_value [WINDOW_MAX];
   logic [TW-1:0]              cell_tag   [WINDOW_MAX];
   logic                       cell_gt    [WINDOW_MAX];
   logic                       cell_rem   [WINDOW_MAX];
   logic signed [SAMPLE_W-1:0] cell_sh_value [WINDOW_MAX];
   logic [TW-1:0]              cell_sh_tag   [WINDOW_MAX];
   logic                       cell_sh_gt    [WINDOW_MAX];

   always_comb begin
      ws_ext = CMPW'(window_size_ff);
      if (ws_ext == '0) begin
         w_ext = CMPW'(1);
      end else if (ws_ext > CMPW'(WINDOW_MAX)) begin
         w_ext = CMPW'(WINDOW_MAX);
      end else begin
         w_ext = ws_ext;
      end
      w = w_ext[CW-1:0];

      fill_eff   = req_restart ? '0 : fill_ff;
      oldest_eff = req_restart ? '0 : CW'(oldest_ff);
      if (oldest_eff >= w) begin
         oldest_eff = '0;
      end
      full       = fill_eff >= w;
      oldest_inc = oldest_eff + CW'(1);
      fill_new   = full ? w : fill_eff + CW'(1);
      emit       = fill_new >= w;
      count      = full ? w : fill_eff;
      old_tag    = oldest_eff[TW-1:0];
      new_tag    = full ? oldest_eff[TW-1:0] : fill_eff[TW-1:0];

      pend_go   = !rsp_valid_ff || rsp_ready;
      req_ready = !pend_ff || pend_go;
      accept    = req_valid && req_ready;

      ctrl.load   = accept;
      ctrl.full   = full;
      ctrl.sample = req_sample;

      window_size_in = window_size_ff;
      fill_in        = fill_ff;
      oldest_in      = oldest_ff;
      if (csr_write_enable) begin
         window_size_in = csr_write_data;
         fill_in        = '0;
         oldest_in      = '0;
      end else if (accept) begin
         fill_in = fill_new;
         if (full) begin
            oldest_in = (oldest_inc >= w) ? '0 : oldest_inc[TW-1:0];
         end else begin
            oldest_in = '0;
         end
      end

      // median taps read the settled cell row
      lo_idx   = TW'((w - CW'(1)) >> 1);
      hi_idx   = TW'(w >> 1);
      lo_value = cell_value[lo_idx];
      hi_value = cell_value[hi_idx];

      median_in = median_ff;
      if (pend_ff && pend_go) begin
         median_in = {lo_value[SAMPLE_W-1], lo_value} + {hi_value[SAMPLE_W-1], hi_value};
      end

      if (accept && emit) begin
         pend_in = 1'b1;
      end else begin
         pend_in = pend_ff && !pend_go;
      end

      if (pend_ff && pend_go) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp_ready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_size_ff <= WSIZE_RESET;
         fill_ff        <= '0;
         oldest_ff      <= '0;
         pend_ff        <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         window_size_ff <= window_size_in;
         fill_ff        <= fill_in;
         oldest_ff      <= oldest_in;
         pend_ff        <= pend_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      median_ff <= median_in;
   end

   for (genvar k = 0; k < WINDOW_MAX; k++) begin : g_cell
      logic signed [SAMPLE_W-1:0] nxt_value;
      logic [TW-1:0]              nxt_tag;
      logic                       nxt_gt;
      logic signed [SAMPLE_W-1:0] prv_sh_value;
      logic [TW-1:0]              prv_sh_tag;
      logic                       prv_sh_gt;
      logic                       prv_rem;

      if (k == WINDOW_MAX - 1) begin : g_last
         assign nxt_value = '0;
         assign nxt_tag   = '0;
         assign nxt_gt    = 1'b1;
      end else begin : g_mid
         assign nxt_value = cell_value[k+1];
         assign nxt_tag   = cell_tag[k+1];
         assign nxt_gt    = cell_gt[k+1];
      end

      if (k == 0) begin : g_first
         assign prv_sh_value = '0;
         assign prv_sh_tag   = '0;
         assign prv_sh_gt    = 1'b0;
         assign prv_rem      = 1'b0;
      end else begin : g_inner
         assign prv_sh_value = cell_sh_value[k-1];
         assign prv_sh_tag   = cell_sh_tag[k-1];
         assign prv_sh_gt    = cell_sh_gt[k-1];
         assign prv_rem      = cell_rem[k-1];
      end

      swm_cell #(
         .INDEX (k),
         .CW    (CW),
         .TW    (TW)
      ) u_cell (
         .clock        (clock),
         .ctrl         (ctrl),
         .count        (count),
         .old_tag      (old_tag),
         .new_tag      (new_tag),
         .nxt_value    (nxt_value),
         .nxt_tag      (nxt_tag),
         .nxt_gt       (nxt_gt),
         .prv_sh_value (prv_sh_value),
         .prv_sh_tag   (prv_sh_tag),
         .prv_sh_gt    (prv_sh_gt),
         .prv_rem      (prv_rem),
         .value        (cell_value[k]),
         .tag          (cell_tag[k]),
         .gt           (cell_gt[k]),
         .rem          (cell_rem[k]),
         .sh_value     (cell_sh_value[k]),
         .sh_tag       (cell_sh_tag[k]),
         .sh_gt        (cell_sh_gt[k])
      );
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_median_doubled = median_ff;

endmodule

// ===== rtl/swm_checker.sv =====
// ----------------------------------------------------------------------------
// Sliding window median - port checker
// Watches the top level ports for handshake and flow-control slips.
// ----------------------------------------------------------------------------
`include "sliding_window_median_unit_macros.svh"

module swm_port_checker
   import swm_pkg::*;
(
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic signed [MEDIAN_W-1:0] rsp_median_doubled
);

   `SWM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_median_doubled))

   `SWM_ASSERT_FROM_RESET(a_reset_clear, clock, reset, !rsp_valid && req_ready)

   `SWM_ASSERT_NOW(a_stall_cause, clock, reset, !req_ready, rsp_valid && !rsp_ready)

   `SWM_ASSERT_NOW(a_rsp_source, clock, reset, $rose(rsp_valid), $past(req_valid && req_ready, 2))

endmodule

bind sliding_window_median_unit swm_port_checker u_swm_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_ready          (req_ready),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_median_doubled (rsp_median_doubled)
);

// ===== verif/swm_checker.sv =====
// ----------------------------------------------------------------------------
// Sliding window median checker
// Watches the sample, median and window size ports of the unit. It keeps its
// own ring and sorted row for the current window and predicts the doubled
// median of each accepted sample once the window is full. Each returned
// median is compared in order with the oldest prediction. Errors and
// outstanding predictions go to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module swm_checker
   import swm_pkg::*;
#(
   parameter int WINDOW_MAX = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_ready,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   input  logic                       req_restart,
   input  logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  logic signed [MEDIAN_W-1:0] rsp_median_doubled,
   input  logic                       csr_write_enable,
   input  logic [WSIZE_W-1:0]         csr_write_data,
   output int                         mismatch_count,
   output int                         medians_pending
);

   logic signed [SAMPLE_W-1:0] arrival_ring  [WINDOW_MAX];
   logic signed [SAMPLE_W-1:0] ordered_cells [WINDOW_MAX];
   logic [WSIZE_W-1:0]         window_reg;
   int unsigned                held_count;
   int unsigned                oldest_slot;
   logic signed [MEDIAN_W-1:0] medians_due [$];
   int                         errors = 0;

   function automatic int unsigned window_length();
      if (window_reg == '0) return 1;
      if (window_reg > WINDOW_MAX) return WINDOW_MAX;
      return int'(window_reg);
   endfunction

   function automatic void cells_remove(input int unsigned n,
                                        input logic signed [SAMPLE_W-1:0] value);
      int unsigned i;
      i = 0;
      while (i < n && ordered_cells[i] != value) i++;
      while (i + 1 < n) begin
         ordered_cells[i] = ordered_cells[i + 1];
         i++;
      end
   endfunction

   function automatic void cells_insert(input int unsigned n,
                                        input logic signed [SAMPLE_W-1:0] value);
      int unsigned i;
      i = n;
      while (i > 0 && ordered_cells[i - 1] > value) begin
         ordered_cells[i] = ordered_cells[i - 1];
         i--;
      end
      ordered_cells[i] = value;
   endfunction

   function automatic void take_sample(input logic signed [SAMPLE_W-1:0] value,
                                       input logic restart);
      int unsigned                w;
      int unsigned                slot;
      logic signed [MEDIAN_W-1:0] lower;
      logic signed [MEDIAN_W-1:0] upper;
      w = window_length();
      if (restart) begin
         held_count  = 0;
         oldest_slot = 0;
      end
      if (held_count >= w) begin
         slot = (oldest_slot >= w) ? 0 : oldest_slot;
         cells_remove(w, arrival_ring[slot]);
         cells_insert(w - 1, value);
         arrival_ring[slot] = value;
         oldest_slot = (slot + 1 >= w) ? 0 : slot + 1;
         held_count  = w;
      end else begin
         cells_insert(held_count, value);
         arrival_ring[held_count] = value;
         held_count++;
         oldest_slot = 0;
      end
      if (held_count >= w) begin
         lower = ordered_cells[(w - 1) / 2];
         upper = ordered_cells[w / 2];
         medians_due.insert(medians_due.size(), lower + upper);
      end
   endfunction

   always @(posedge clock) begin : watch
      logic signed [MEDIAN_W-1:0] due;
      if (reset) begin
         window_reg  = WSIZE_RESET;
         held_count  = 0;
         oldest_slot = 0;
         medians_due.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (medians_due.size() == 0) begin
               errors++;
               $error("median_doubled: expected none, actual %0d", rsp_median_doubled);
            end else begin
               due = medians_due.pop_front();
               if (due !== rsp_median_doubled) begin
                  errors++;
                  $error("median_doubled: expected %0d, actual %0d",
                         due, rsp_median_doubled);
               end
            end
         end
         if (csr_write_enable) begin
            window_reg  = csr_write_data;
            held_count  = 0;
            oldest_slot = 0;
         end
         if (req_valid && req_ready) take_sample(req_sample, req_restart);
      end
      mismatch_count  <= errors;
      medians_pending <= medians_due.size();
   end

endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// Sliding window median unit testbench
// Drives samples with random gaps and restarts through a series of window
// sizes, from zero up to beyond the maximum. The result side stalls at random
// and once holds off long enough to back the unit up. A checker beside the
// unit predicts every median; this level gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
   import swm_pkg::*;

   localparam int WINDOW_MAX = 64;
   localparam int PHASES     = 10;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 32'sh8000_0000;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 32'sh7FFF_FFFF;

   logic                       clock              = 1'b0;
   logic                       reset              = 1'b1;
   logic                       req_valid          = 1'b0;
   logic                       req_ready;
   logic signed [SAMPLE_W-1:0] req_sample         = '0;
   logic                       req_restart        = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_ready          = 1'b0;
   logic signed [MEDIAN_W-1:0] rsp_median_doubled;
   logic                       csr_write_enable   = 1'b0;
   logic [WSIZE_W-1:0]         csr_write_data     = '0;
   int                         mismatch_count;
   int                         medians_pending;
   int                         samples_taken      = 0;

   logic [WSIZE_W-1:0] window_plan [PHASES] =
      '{7'd3, 7'd1, 7'd2, 7'd0, 7'd64, 7'd127, 7'd5, 7'd8, 7'd17, 7'd32};
   int                 count_plan  [PHASES] =
      '{45, 25, 30, 20, 75, 72, 25, 25, 40, 45};

   always #4 clock = ~clock;

   sliding_window_median_unit #(
      .WINDOW_MAX(WINDOW_MAX)
   ) u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_sample         (req_sample),
      .req_restart        (req_restart),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_median_doubled (rsp_median_doubled),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data)
   );

   swm_checker #(
      .WINDOW_MAX(WINDOW_MAX)
   ) u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_sample         (req_sample),
      .req_restart        (req_restart),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_median_doubled (rsp_median_doubled),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data),
      .mismatch_count     (mismatch_count),
      .medians_pending    (medians_pending)
   );

   function automatic logic signed [SAMPLE_W-1:0] pick_sample();
      int unsigned mode;
      mode = $urandom_range(0, 99);
      if (mode < 45) return $urandom;
      if (mode < 80) return int'($urandom_range(0, 20)) - 10;
      case ($urandom_range(0, 3))
         0: return SAMPLE_MIN;
         1: return SAMPLE_MAX;
         2: return SAMPLE_MIN + 1;
         default: return SAMPLE_MAX - 1;
      endcase
   endfunction

   task automatic push_sample(input logic signed [SAMPLE_W-1:0] value,
                              input logic restart);
      while (!(samples_taken >= 150 && samples_taken < 230) &&
             $urandom_range(0, 99) < 9) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_sample  <= value;
      req_restart <= restart;
      do @(posedge clock); while (!req_ready);
      samples_taken++;
   endtask

   task automatic wait_drained();
      do @(posedge clock); while (medians_pending != 0);
   endtask

   task automatic set_window(input logic [WSIZE_W-1:0] value);
      wait_drained();
      repeat (6) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // result side: random stalls, one long hold-off, one stretch always ready
   initial begin : rsp_side
      int cycles;
      bit held;
      cycles = 0;
      held   = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (!held && samples_taken >= 40) begin
            held = 1'b1;
            rsp_ready <= 1'b0;
            repeat (200) @(posedge clock);
            cycles += 200;
         end else begin
            rsp_ready <= (cycles >= 1200 && cycles < 1800) ||
                         ($urandom_range(0, 99) >= 9);
            @(posedge clock);
            cycles++;
         end
      end
   end

   initial begin : stimulus
      int unsigned restart_pct;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      push_sample(0, 1'b0);
      push_sample(SAMPLE_MAX, 1'b0);
      push_sample(SAMPLE_MIN, 1'b0);
      push_sample(SAMPLE_MIN, 1'b0);
      push_sample(SAMPLE_MIN, 1'b0);
      push_sample(SAMPLE_MAX, 1'b0);
      push_sample(SAMPLE_MAX, 1'b0);
      push_sample(SAMPLE_MAX, 1'b0);
      push_sample(-1, 1'b0);
      push_sample(-1, 1'b0);
      push_sample(5, 1'b1);
      push_sample(5, 1'b0);
      push_sample(5, 1'b0);
      push_sample(7, 1'b0);
      push_sample(32'sh5555_5555, 1'b0);
      push_sample(32'shAAAA_AAAA, 1'b0);

      for (int ph = 0; ph < PHASES; ph++) begin
         if (ph > 0) set_window(window_plan[ph]);
         case (window_plan[ph])
            7'd1: begin
               push_sample(7, 1'b1);
               push_sample(SAMPLE_MIN, 1'b0);
               push_sample(SAMPLE_MAX, 1'b1);
            end
            7'd2: begin
               push_sample(SAMPLE_MAX, 1'b0);
               push_sample(SAMPLE_MIN, 1'b0);
               push_sample(-1, 1'b0);
               push_sample(-2, 1'b0);
            end
            default: ;
         endcase
         restart_pct = (window_plan[ph] > 7'd8) ? 1 : 4;
         for (int n = 0; n < count_plan[ph]; n++)
            push_sample(pick_sample(), $urandom_range(0, 99) < restart_pct);
         req_valid <= 1'b0;
      end

      wait_drained();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && medians_pending == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin : watchdog
      #2_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
